// ===== rtl/core/blr_pkg.sv =====
package blr_pkg;

   localparam int COORD_BITS = 10;
   localparam int ERR_BITS = COORD_BITS + 1;
   localparam int CFG_BITS = 10;
   localparam int CSR_INDEX_BITS = 1;
   localparam int COLOR_BITS = 32;
   localparam int STATUS_BITS = 3;
   localparam int CMP_BITS = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET = CFG_BITS'(640);
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = CSR_INDEX_BITS'(1);

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_PIXEL = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ACCEPTED = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_VERTICAL = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_LINE = 3'd4;

   typedef struct packed {
      logic                  cmd;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
      logic [COLOR_BITS-1:0] pen_color;
   } req_item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]  pixel_x;
      logic [COORD_BITS-1:0]  pixel_y;
      logic [COLOR_BITS-1:0]  pixel_color;
      logic                   is_last;
      logic [STATUS_BITS-1:0] status;
   } rsp_item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] cur_x;
      logic [COORD_BITS-1:0] cur_y;
      logic [COORD_BITS-1:0] goal_x;
      logic [COORD_BITS-1:0] goal_y;
      logic [ERR_BITS-1:0]   err_acc;
      logic [COORD_BITS-1:0] major_delta;
      logic [COORD_BITS-1:0] minor_delta;
      logic                  x_down;
      logic                  y_down;
      logic                  y_major;
      logic                  active;
      logic [COLOR_BITS-1:0] held_color;
   } line_state_type;

endpackage

// ===== rtl/core/blr_csr.sv =====
module blr_csr
   import blr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data,
   output logic [CFG_BITS-1:0]       screen_width,
   output logic [CFG_BITS-1:0]       screen_height
);

   logic [CFG_BITS-1:0] width_ff, width_in;
   logic [CFG_BITS-1:0] height_ff, height_in;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: width_in = csr_data;
            CSR_SCREEN_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
      end
   end

   assign screen_width = width_ff;
   assign screen_height = height_ff;

endmodule

// ===== rtl/core/blr_step.sv =====
module blr_step
   import blr_pkg::*;
(
   input  req_item_type        item,
   input  line_state_type      state,
   input  logic [CFG_BITS-1:0] screen_width,
   input  logic [CFG_BITS-1:0] screen_height,
   output line_state_type      state_next,
   output rsp_item_type        result
);

   logic [CMP_BITS-1:0]   xs_w, xe_w, ys_w, ye_w, width_w, height_w;
   logic                  out_of_range;
   logic                  x_neg, y_neg;
   logic [COORD_BITS-1:0] dx, dy;
   logic                  dy_major;
   logic [ERR_BITS-1:0]   err_sum;
   logic                  minor_step;
   logic [ERR_BITS-1:0]   err_next;
   logic [COORD_BITS-1:0] x_moved, y_moved;
   logic [COORD_BITS-1:0] step_x, step_y;
   logic                  last;

   always_comb begin
      xs_w = CMP_BITS'(item.x_start);
      xe_w = CMP_BITS'(item.x_end);
      ys_w = CMP_BITS'(item.y_start);
      ye_w = CMP_BITS'(item.y_end);
      width_w = CMP_BITS'(screen_width);
      height_w = CMP_BITS'(screen_height);
      out_of_range = (item.x_start == '0) || (item.x_end == '0) ||
                     (item.y_start == '0) || (item.y_end == '0) ||
                     (xs_w >= width_w) || (xe_w >= width_w) ||
                     (ys_w >= height_w) || (ye_w >= height_w);
      x_neg = item.x_end < item.x_start;
      y_neg = item.y_end < item.y_start;
      dx = x_neg ? item.x_start - item.x_end : item.x_end - item.x_start;
      dy = y_neg ? item.y_start - item.y_end : item.y_end - item.y_start;
      dy_major = dy > dx;
   end

   // error stays below twice the major delta, so the sum cannot wrap
   always_comb begin
      err_sum = state.err_acc + ERR_BITS'(state.minor_delta);
      minor_step = err_sum >= ERR_BITS'(state.major_delta);
      err_next = minor_step ? err_sum - ERR_BITS'(state.major_delta) : err_sum;
      x_moved = state.x_down ? state.cur_x - 1'b1 : state.cur_x + 1'b1;
      y_moved = state.y_down ? state.cur_y - 1'b1 : state.cur_y + 1'b1;
      if (state.y_major) begin
         step_y = y_moved;
         step_x = minor_step ? x_moved : state.cur_x;
         last = y_moved == state.goal_y;
      end else begin
         step_x = x_moved;
         step_y = minor_step ? y_moved : state.cur_y;
         last = x_moved == state.goal_x;
      end
   end

   always_comb begin
      state_next = state;
      result = '0;
      case (item.cmd)
         CMD_START: begin
            state_next.active = 1'b0;
            if (out_of_range) begin
               result.status = STATUS_RANGE;
            end else if (item.x_start == item.x_end) begin
               result.status = STATUS_VERTICAL;
            end else begin
               state_next.cur_x = item.x_start;
               state_next.cur_y = item.y_start;
               state_next.goal_x = item.x_end;
               state_next.goal_y = item.y_end;
               state_next.x_down = x_neg;
               state_next.y_down = y_neg;
               state_next.y_major = dy_major;
               state_next.major_delta = dy_major ? dy : dx;
               state_next.minor_delta = dy_major ? dx : dy;
               state_next.err_acc = ERR_BITS'((dy_major ? dy : dx) >> 1);
               state_next.held_color = item.pen_color;
               state_next.active = 1'b1;
               result.pixel_x = item.x_start;
               result.pixel_y = item.y_start;
               result.pixel_color = item.pen_color;
               result.status = STATUS_ACCEPTED;
            end
         end
         CMD_STEP: begin
            if (!state.active) begin
               result.status = STATUS_NO_LINE;
            end else begin
               state_next.err_acc = err_next;
               state_next.cur_x = step_x;
               state_next.cur_y = step_y;
               state_next.active = !last;
               result.pixel_x = step_x;
               result.pixel_y = step_y;
               result.pixel_color = state.held_color;
               result.is_last = last;
               result.status = STATUS_PIXEL;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/core/line_rasterizer_bresenham_unit.sv =====
// Bresenham line rasterizer, all eight octants.
// req_ channel: one item per command. cmd start latches a line (endpoints
// and colour) and answers with the start pixel or a reject status; cmd step
// answers with the next pixel (is_last marks the end point) or STATUS_NO_LINE.
// rsp_ channel: exactly one result item per request item, in order.
// csr_ channel: screen_width (index 0) and screen_height (index 1); always
// ready, write only while no item is in flight.
// Path: an accepted item passes through the input register, then the result
// register. Throughput: one item per cycle while rsp_stall is low; the step
// arithmetic (one add, one compare, one subtract, coordinate increments) sits
// between the input register and the line state / result registers.
// Reset clears both registers' valid flags, the line state (no active line)
// and loads the screen bounds with 640 and 480.
// While rsp_stall is high the result register holds; one further item is
// taken into the input register, after which req_stall rises.
module line_rasterizer_bresenham_unit
   import blr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_item_type              req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_item_type              rsp_item,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   logic [CFG_BITS-1:0] screen_width;
   logic [CFG_BITS-1:0] screen_height;

   logic           in_valid_ff, in_valid_in;
   req_item_type   in_item_ff, in_item_in;
   logic           out_valid_ff, out_valid_in;
   rsp_item_type   out_item_ff, out_item_in;
   line_state_type state_ff, state_in;
   line_state_type state_next;
   rsp_item_type   step_result;
   logic           out_free;
   logic           fire;
   logic           req_take;

   blr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .screen_width (screen_width),
      .screen_height(screen_height)
   );

   blr_step u_step (
      .item         (in_item_ff),
      .state        (state_ff),
      .screen_width (screen_width),
      .screen_height(screen_height),
      .state_next   (state_next),
      .result       (step_result)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in = out_item_ff;
      state_in = state_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
      if (fire) begin
         out_item_in = step_result;
         state_in = state_next;
         in_valid_in = 1'b0;
      end
      // refill the input register whenever it empties or is drained
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
      end
      in_item_ff <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item = out_item_ff;

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      fire && step_result.is_last |=> !state_ff.active)
      else $error("line still active after end pixel");

   a_pixel_needs_line: assert property (@(posedge clock) disable iff (reset)
      fire && in_item_ff.cmd == CMD_STEP && step_result.status == STATUS_PIXEL
      |-> state_ff.active)
      else $error("pixel produced without an active line");

   a_reject_ends_line: assert property (@(posedge clock) disable iff (reset)
      fire && in_item_ff.cmd == CMD_START && step_result.status != STATUS_ACCEPTED
      |=> !state_ff.active)
      else $error("rejected start left a line active");

   a_fire_loads_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed item did not reach the result register");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("input stalled with room to spare");

endmodule

// ===== verif/tb_line_rasterizer_bresenham_unit.sv =====
`timescale 1ns / 1ps

module tb_line_rasterizer_bresenham_unit;
   import blr_pkg::*;

   typedef enum {JOB_ITEM, JOB_CSR, JOB_DRAIN, JOB_IDLE_MODE} job_kind_type;

   typedef struct {
      job_kind_type              kind;
      req_item_type              item;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CFG_BITS-1:0]       data;    // idle percentage for JOB_IDLE_MODE
   } stroke_job_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_item_type              req_item = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_item_type              rsp_item;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_data = '0;

   // predictor copy of the line state and the screen bounds
   logic [CFG_BITS-1:0]   bound_w = WIDTH_RESET;
   logic [CFG_BITS-1:0]   bound_h = HEIGHT_RESET;
   logic [COORD_BITS-1:0] pen_x = '0, pen_y = '0, end_x = '0, end_y = '0;
   logic [ERR_BITS-1:0]   err_term = '0;
   logic [COORD_BITS-1:0] major_len = '0, minor_len = '0;
   logic                  x_dec = 1'b0, y_dec = 1'b0, y_major = 1'b0;
   logic                  drawing = 1'b0;
   logic [COLOR_BITS-1:0] line_color = '0;

   stroke_job_type stroke_plan[$];
   rsp_item_type   pending_pixels[$];

   logic req_fire = 1'b0;
   logic csr_fire = 1'b0;
   int   idle_pct = 36;
   int   settle_count = 0;
   int   fault_count = 0;
   int   report_count = 0;
   int   items_taken = 0;
   int   bounds_written = 0;
   int   status_seen[8];
   int   spin;

   line_rasterizer_bresenham_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic rsp_item_type next_pixel(req_item_type r);
      rsp_item_type          res;
      logic [COORD_BITS-1:0] dx, dy;
      logic                  hop, done;
      res = '0;
      if (r.cmd == CMD_START) begin
         drawing = 1'b0;
         if (r.x_start == 0 || r.x_end == 0 || r.y_start == 0 || r.y_end == 0 ||
             r.x_start >= bound_w || r.x_end >= bound_w ||
             r.y_start >= bound_h || r.y_end >= bound_h) begin
            res.status = STATUS_RANGE;
         end else if (r.x_start == r.x_end) begin
            res.status = STATUS_VERTICAL;
         end else begin
            x_dec = r.x_end < r.x_start;
            y_dec = r.y_end < r.y_start;
            dx = x_dec ? r.x_start - r.x_end : r.x_end - r.x_start;
            dy = y_dec ? r.y_start - r.y_end : r.y_end - r.y_start;
            y_major = dx < dy;
            major_len = y_major ? dy : dx;
            minor_len = y_major ? dx : dy;
            err_term = ERR_BITS'(major_len >> 1);
            pen_x = r.x_start;
            pen_y = r.y_start;
            end_x = r.x_end;
            end_y = r.y_end;
            line_color = r.pen_color;
            drawing = 1'b1;
            res.pixel_x = pen_x;
            res.pixel_y = pen_y;
            res.pixel_color = line_color;
            res.status = STATUS_ACCEPTED;
         end
      end else if (!drawing) begin
         res.status = STATUS_NO_LINE;
      end else begin
         err_term = err_term + ERR_BITS'(minor_len);
         hop = err_term >= ERR_BITS'(major_len);
         if (hop)
            err_term = err_term - ERR_BITS'(major_len);
         if (y_major) begin
            pen_y = y_dec ? pen_y - 1'b1 : pen_y + 1'b1;
            if (hop)
               pen_x = x_dec ? pen_x - 1'b1 : pen_x + 1'b1;
            done = pen_y == end_y;
         end else begin
            pen_x = x_dec ? pen_x - 1'b1 : pen_x + 1'b1;
            if (hop)
               pen_y = y_dec ? pen_y - 1'b1 : pen_y + 1'b1;
            done = pen_x == end_x;
         end
         if (done)
            drawing = 1'b0;
         res.pixel_x = pen_x;
         res.pixel_y = pen_y;
         res.pixel_color = line_color;
         res.is_last = done;
         res.status = STATUS_PIXEL;
      end
      return res;
   endfunction

   function automatic void plan_item(logic cmd, int xs, int ys, int xe, int ye,
                                     logic [COLOR_BITS-1:0] col);
      stroke_job_type job;
      job.kind = JOB_ITEM;
      job.item.cmd = cmd;
      job.item.x_start = COORD_BITS'(xs);
      job.item.y_start = COORD_BITS'(ys);
      job.item.x_end = COORD_BITS'(xe);
      job.item.y_end = COORD_BITS'(ye);
      job.item.pen_color = col;
      job.index = '0;
      job.data = '0;
      stroke_plan.push_back(job);
   endfunction

   function automatic void plan_step();
      plan_item(CMD_STEP, $urandom_range(1023), $urandom_range(1023),
                $urandom_range(1023), $urandom_range(1023), $urandom);
   endfunction

   task automatic plan_ctrl(job_kind_type kind, logic [CSR_INDEX_BITS-1:0] idx, int value);
      stroke_job_type job;
      job.kind = kind;
      job.item = '0;
      job.index = idx;
      job.data = CFG_BITS'(value);
      stroke_plan.push_back(job);
   endtask

   task automatic plan_csr(logic [CSR_INDEX_BITS-1:0] idx, int value);
      plan_ctrl(JOB_DRAIN, '0, 0);
      plan_ctrl(JOB_CSR, idx, value);
   endtask

   // start a line, then step it to the end; cut > 0 drops steps, cut < 0 adds steps
   function automatic int plan_line(int xs, int ys, int xe, int ye, int cut,
                                    logic [COLOR_BITS-1:0] col);
      int dx, dy, steps;
      dx = (xe > xs) ? xe - xs : xs - xe;
      dy = (ye > ys) ? ye - ys : ys - ye;
      steps = ((dx >= dy) ? dx : dy) - cut;
      if (steps < 0)
         steps = 0;
      plan_item(CMD_START, xs, ys, xe, ye, col);
      repeat (steps) plan_step();
      return steps + 1;
   endfunction

   function automatic int pick_end(int from, int hi, int reach, bit may_stay);
      int mag, to;
      mag = $urandom_range(reach, may_stay ? 0 : 1);
      to = $urandom_range(1) ? from + mag : from - mag;
      if (to < 1 || to > hi)
         to = 2 * from - to;
      if (to < 1)
         to = 1;
      if (to > hi)
         to = hi;
      if (!may_stay && to == from)
         to = (from == 1) ? 2 : 1;
      return to;
   endfunction

   task automatic plan_random(int budget, int w, int h);
      int used, xs, ys, xe, ye, reach, cut;
      used = 0;
      while (used < budget) begin
         if ($urandom_range(99) < 80 && w >= 3 && h >= 2) begin
            reach = ($urandom_range(99) < 4) ? 255 : 12;
            xs = $urandom_range(w - 1, 1);
            ys = $urandom_range(h - 1, 1);
            xe = pick_end(xs, w - 1, reach, 1'b0);
            ye = ($urandom_range(9) == 0) ? ys : pick_end(ys, h - 1, reach, 1'b1);
            case ($urandom_range(9))
               0: cut = $urandom_range(3, 1);
               1: cut = -$urandom_range(2, 1);
               default: cut = 0;
            endcase
            used += plan_line(xs, ys, xe, ye, cut, $urandom);
         end else begin
            plan_item(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
                      $urandom_range(1023), $urandom_range(1023), $urandom);
            used++;
         end
      end
   endtask

   // drive on the falling edge; hold a stalled item until it is taken
   always @(negedge clock) begin : drive_ports
      stroke_job_type job;
      logic           keep_req, keep_csr, raise_req, raise_csr;
      keep_req = req_valid && !req_fire;
      keep_csr = csr_valid && !csr_fire;
      raise_req = 1'b0;
      raise_csr = 1'b0;
      if ((req_valid && req_fire) || (csr_valid && csr_fire))
         stroke_plan.delete(0);
      rsp_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
      if (!reset && !keep_req && !keep_csr && stroke_plan.size() != 0) begin
         job = stroke_plan[0];
         case (job.kind)
            JOB_ITEM: begin
               if (idle_pct == 0 || $urandom_range(99) >= idle_pct) begin
                  req_item <= job.item;
                  raise_req = 1'b1;
               end
            end
            JOB_CSR: begin
               csr_index <= job.index;
               csr_data <= job.data;
               raise_csr = 1'b1;
            end
            JOB_DRAIN: begin
               // wait for every pixel in flight, then let settle_count run up while idle
               settle_count = (pending_pixels.size() == 0) ? settle_count + 1 : 0;
               if (settle_count > 4) begin
                  settle_count = 0;
                  stroke_plan.delete(0);
               end
            end
            JOB_IDLE_MODE: begin
               idle_pct = int'(job.data);
               stroke_plan.delete(0);
            end
            default: ;
         endcase
      end
      if (!keep_req)
         req_valid <= raise_req;
      if (!keep_csr)
         csr_valid <= raise_csr;
   end

   always @(posedge clock) begin : watch_ports
      rsp_item_type want;
      req_fire <= !reset && req_valid && !req_stall;
      csr_fire <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               fault_count++;
               if (report_count < 10) begin
                  report_count++;
                  $display("%0t: result with none expected: x %0d y %0d colour %h last %0d st %0d",
                           $realtime, rsp_item.pixel_x, rsp_item.pixel_y,
                           rsp_item.pixel_color, rsp_item.is_last, rsp_item.status);
               end
            end else begin
               want = pending_pixels.pop_front();
               status_seen[want.status]++;
               if (rsp_item.pixel_x !== want.pixel_x || rsp_item.pixel_y !== want.pixel_y ||
                   rsp_item.pixel_color !== want.pixel_color ||
                   rsp_item.is_last !== want.is_last || rsp_item.status !== want.status) begin
                  fault_count++;
                  if (report_count < 10) begin
                     report_count++;
                     $display("%0t: mismatch exp x %0d y %0d colour %h last %0d st %0d",
                              $realtime, want.pixel_x, want.pixel_y, want.pixel_color,
                              want.is_last, want.status);
                     $display("%0t:          got x %0d y %0d colour %h last %0d st %0d",
                              $realtime, rsp_item.pixel_x, rsp_item.pixel_y,
                              rsp_item.pixel_color, rsp_item.is_last, rsp_item.status);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_pixels.push_back(next_pixel(req_item));
            items_taken++;
         end
         if (csr_valid && csr_ready) begin
            bounds_written++;
            case (csr_index)
               CSR_SCREEN_WIDTH: bound_w = csr_data;
               CSR_SCREEN_HEIGHT: bound_h = csr_data;
               default: ;
            endcase
         end
      end
   end

   initial begin
      // directed part, reset bounds 640 x 480
      plan_step();
      plan_item(CMD_START, 0, 5, 9, 5, 32'h1234_5678);
      plan_item(CMD_START, 5, 5, 9, 480, 32'h0F0F_0F0F);
      plan_item(CMD_START, 5, 5, 640, 5, 32'hA5A5_A5A5);
      plan_item(CMD_START, 1023, 1023, 1023, 1023, 32'hFFFF_FFFF);
      plan_item(CMD_START, 7, 3, 7, 9, 32'h0000_0001);
      void'(plan_line(1, 1, 4, 1, 0, 32'h0000_0000));
      void'(plan_line(10, 10, 8, 4, 0, 32'hFFFF_FFFF));
      void'(plan_line(3, 3, 1, 1, 0, 32'h8000_0000));
      void'(plan_line(639, 479, 638, 477, 0, 32'h5555_AAAA));
      plan_step();
      // a rejected start ends the line in progress
      void'(plan_line(2, 2, 5, 3, 2, 32'hC3C3_C3C3));
      plan_item(CMD_START, 4, 2, 4, 6, 32'h7777_7777);
      plan_step();

      plan_random(180, 640, 480);
      plan_ctrl(JOB_DRAIN, '0, 0);
      plan_random(170, 640, 480);

      plan_csr(CSR_SCREEN_WIDTH, 1023);
      plan_csr(CSR_SCREEN_HEIGHT, 1023);
      void'(plan_line(1022, 1022, 1019, 1020, 0, $urandom));
      void'(plan_line(1, 1022, 3, 1019, 0, $urandom));
      plan_item(CMD_START, 1023, 5, 9, 5, $urandom);
      plan_random(300, 1023, 1023);
      plan_ctrl(JOB_IDLE_MODE, '0, 0);
      plan_random(250, 1023, 1023);
      plan_ctrl(JOB_IDLE_MODE, '0, 36);

      plan_csr(CSR_SCREEN_WIDTH, 1);
      plan_csr(CSR_SCREEN_HEIGHT, 1);
      plan_random(40, 1, 1);
      plan_csr(CSR_SCREEN_WIDTH, 0);
      plan_csr(CSR_SCREEN_HEIGHT, 0);
      plan_random(30, 0, 0);
      plan_csr(CSR_SCREEN_WIDTH, 20);
      plan_csr(CSR_SCREEN_HEIGHT, 12);
      plan_random(250, 20, 12);
      plan_csr(CSR_SCREEN_WIDTH, 511);
      plan_csr(CSR_SCREEN_HEIGHT, 512);
      plan_random(150, 511, 512);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stroke_plan.size() != 0 || req_valid || csr_valid)
         @(posedge clock);
      for (spin = 0; spin < 1000 && pending_pixels.size() != 0; spin++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         fault_count += pending_pixels.size();
         $display("%0d expected results never arrived", pending_pixels.size());
      end

      $display("Covered %0d items over %0d bound writes: %0d lines drawn, %0d pixels stepped.",
               items_taken, bounds_written, status_seen[STATUS_ACCEPTED],
               status_seen[STATUS_PIXEL]);
      $display("Rejects: %0d out of range, %0d vertical, %0d steps without a line; %0d faults.",
               status_seen[STATUS_RANGE], status_seen[STATUS_VERTICAL],
               status_seen[STATUS_NO_LINE], fault_count);
      if (fault_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding", pending_pixels.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== line_rasterizer_bresenham_unit.f =====
rtl/core/blr_pkg.sv
rtl/core/blr_csr.sv
rtl/core/blr_step.sv
rtl/core/line_rasterizer_bresenham_unit.sv
verif/tb_line_rasterizer_bresenham_unit.sv
